// ===== sv/linear_constraint_entry_bounds_unit_defines.svh =====
`ifndef LINEAR_CONSTRAINT_ENTRY_BOUNDS_UNIT_DEFINES_SVH
`define LINEAR_CONSTRAINT_ENTRY_BOUNDS_UNIT_DEFINES_SVH

// Checks that a condition implies another in the same cycle.
`define LCB_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a condition implies another in the following cycle.
`define LCB_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lcb_pkg.sv =====
package lcb_pkg;

	localparam int WORD_W = 32;
	localparam int DEF_MAX_X_COLUMNS = 8;
	localparam int DEF_MAX_Y_COLUMNS = 8;
	localparam int DEF_FRAC_BITS = 16;

	localparam logic [1:0] MODE_LOAD_X = 2'd0;
	localparam logic [1:0] MODE_LOAD_Y = 2'd1;
	localparam logic [1:0] MODE_COMPUTE = 2'd2;

	localparam logic [1:0] REG_LOWER = 2'd0;
	localparam logic [1:0] REG_UPPER = 2'd1;
	localparam logic [1:0] REG_X_COLS = 2'd2;
	localparam logic [1:0] REG_Y_COLS = 2'd3;

	typedef struct packed {
		logic done;
		logic ovf;
		logic signed [WORD_W-1:0] quot;
	} div_res_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SETUP = 6'b000010,
		ST_SUM   = 6'b000100,
		ST_DLO   = 6'b001000,
		ST_DHI   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

endpackage

// ===== sv/lcb_div.sv =====
module lcb_div #(
	parameter int NUM_W = 52,
	parameter int FRAC_BITS = lcb_pkg::DEF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [lcb_pkg::WORD_W-1:0] den,
	output lcb_pkg::div_res_t res
);

	localparam int DIV_W = NUM_W + FRAC_BITS;
	localparam int CNT_W = $clog2(DIV_W + 1);
	localparam int W = lcb_pkg::WORD_W;

	logic [DIV_W-1:0] dvd_q;
	logic [W-1:0] dsr_q;
	logic [W-1:0] rem_q;
	logic [W:0] quot_q;
	logic ovf_q;
	logic neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic done_q;

	logic [NUM_W-1:0] num_mag;
	logic [W:0] rem_sh;
	logic fit;
	logic [W:0] rem_sub;
	logic range_bad;

	assign num_mag = num[NUM_W-1] ? (~num + 1'b1) : num;
	assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};
	assign fit = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_mag, {FRAC_BITS{1'b0}}};
			dsr_q <= den[W-1] ? (~den + 1'b1) : den;
			neg_q <= num[NUM_W-1] ^ den[W-1];
			rem_q <= '0;
			quot_q <= '0;
			ovf_q <= 1'b0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			rem_q <= fit ? rem_sub[W-1:0] : rem_sh[W-1:0];
			quot_q <= {quot_q[W-1:0], fit};
			ovf_q <= ovf_q | quot_q[W];
		end
	end

	always_comb begin
		if (neg_q) begin
			range_bad = quot_q[W] || (quot_q[W-1] && quot_q[W-2:0] != '0);
		end else begin
			range_bad = quot_q[W] || quot_q[W-1];
		end
		res.done = done_q;
		res.ovf = ovf_q | range_bad;
		res.quot = neg_q ? -$signed(quot_q[W-1:0]) : $signed(quot_q[W-1:0]);
	end

endmodule

// ===== sv/linear_constraint_entry_bounds_unit.sv =====
// Channel   Direction  Contents
// s_*       in         tuser: mode; tdata: index, value
// m_*       out        tdata: entry_row, entry_col, min_bound, max_bound; tuser: infeasible;
//                      tlast: last
// cfg_*     in         register writes, index 0 lower, 1 upper, 2 x columns, 3 y columns
// A load leaves s_tready high. A compute holds s_tready low until its last transfer.
// An entry with a zero x element skips the sums and divisions; any other entry gets
// both quotients (Q16.16 at the default FRAC_BITS) from the serial divider, which
// produces them one bit per cycle.
// A stall on m_tready holds the result; the reset is asynchronous and clears control.
`include "linear_constraint_entry_bounds_unit_defines.svh"

module linear_constraint_entry_bounds_unit #(
	parameter int MAX_X_COLUMNS = lcb_pkg::DEF_MAX_X_COLUMNS,
	parameter int MAX_Y_COLUMNS = lcb_pkg::DEF_MAX_Y_COLUMNS,
	parameter int FRAC_BITS = lcb_pkg::DEF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [39:0] s_tdata, // index [2:0], value [34:3], zero fill
	input  logic [1:0] s_tuser,  // mode [1:0]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [71:0] m_tdata, // entry_row [2:0], entry_col [5:3], min_bound [37:6],
	                             // max_bound [69:38], zero fill
	output logic m_tuser,        // infeasible
	output logic m_tlast,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int W = lcb_pkg::WORD_W;
	localparam int XW = MAX_X_COLUMNS > 1 ? $clog2(MAX_X_COLUMNS) : 1;
	localparam int YW = MAX_Y_COLUMNS > 1 ? $clog2(MAX_Y_COLUMNS) : 1;
	localparam int ACC_W = 67 - FRAC_BITS;
	localparam int NUM_W = ACC_W + 1;
	localparam int SLOT_W = 5;

	lcb_pkg::state_t state_q;
	logic signed [W-1:0] lb_q, ub_q;
	logic [3:0] xcols_q, ycols_q;
	logic signed [W-1:0] x_q [MAX_X_COLUMNS];
	logic signed [W-1:0] y_q [MAX_Y_COLUMNS];
	logic [3:0] p_q, q_q, row_q, col_q;
	logic [SLOT_W-1:0] slot_q;
	logic signed [2*W-1:0] prod_s1;
	logic pend_q, which_q, start_q, lo_bad_q;
	logic signed [ACC_W-1:0] smax_q, smin_q;
	logic signed [W-1:0] lo_q;
	logic signed [W-1:0] out_min_q, out_max_q;
	logic out_bad_q, out_last_q;

	logic [2:0] in_index;
	logic signed [W-1:0] in_value;
	logic [3:0] p_sat, q_sat;
	logic signed [W-1:0] xc, xi, bound, yr, mn, mx;
	logic [SLOT_W-2:0] slot_i;
	logic issue, include_i;
	logic signed [ACC_W-1:0] term;
	logic signed [NUM_W-1:0] num;
	lcb_pkg::div_res_t dres;

	assign in_index = s_tdata[2:0];
	assign in_value = s_tdata[34:3];
	assign p_sat = (32'(xcols_q) > MAX_X_COLUMNS) ? 4'(MAX_X_COLUMNS) : xcols_q;
	assign q_sat = (32'(ycols_q) > MAX_Y_COLUMNS) ? 4'(MAX_Y_COLUMNS) : ycols_q;
	assign xc = x_q[col_q[XW-1:0]];
	assign yr = y_q[row_q[YW-1:0]];
	assign slot_i = slot_q[SLOT_W-1:1];
	assign xi = x_q[slot_i[XW-1:0]];
	assign bound = slot_q[0] ? lb_q : ub_q;
	assign issue = {p_q, 1'b0} > slot_q;
	assign include_i = (32'(slot_i) != 32'(col_q)) && (xi > 0);
	assign term = ACC_W'(prod_s1 >>> FRAC_BITS);
	assign num = $signed({{(NUM_W-W){yr[W-1]}}, yr})
		- $signed({state_q == lcb_pkg::ST_DHI ? smin_q[ACC_W-1] : smax_q[ACC_W-1],
		state_q == lcb_pkg::ST_DHI ? smin_q : smax_q});
	assign mn = (lo_q > lb_q) ? lo_q : lb_q;
	assign mx = (dres.quot < ub_q) ? dres.quot : ub_q;

	lcb_div #(
		.NUM_W(NUM_W),
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(start_q),
		.num(num),
		.den(xc),
		.res(dres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lb_q <= '0;
			ub_q <= 32'sd65536;
			xcols_q <= 4'd8;
			ycols_q <= 4'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				lcb_pkg::REG_LOWER: lb_q <= cfg_data;
				lcb_pkg::REG_UPPER: ub_q <= cfg_data;
				lcb_pkg::REG_X_COLS: xcols_q <= cfg_data[3:0];
				lcb_pkg::REG_Y_COLS: ycols_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			if (s_tuser == lcb_pkg::MODE_LOAD_X && 32'(in_index) < MAX_X_COLUMNS) begin
				x_q[in_index[XW-1:0]] <= in_value;
			end
			if (s_tuser == lcb_pkg::MODE_LOAD_Y && 32'(in_index) < MAX_Y_COLUMNS) begin
				y_q[in_index[YW-1:0]] <= in_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcb_pkg::ST_IDLE;
			start_q <= 1'b0;
			pend_q <= 1'b0;
			p_q <= '0;
			q_q <= '0;
			row_q <= '0;
			col_q <= '0;
			slot_q <= '0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				lcb_pkg::ST_IDLE: begin
					if (s_tvalid && s_tuser == lcb_pkg::MODE_COMPUTE
						&& p_sat != '0 && q_sat != '0) begin
						p_q <= p_sat;
						q_q <= q_sat;
						row_q <= '0;
						col_q <= '0;
						state_q <= lcb_pkg::ST_SETUP;
					end
				end
				lcb_pkg::ST_SETUP: begin
					slot_q <= '0;
					pend_q <= 1'b0;
					state_q <= (xc == '0) ? lcb_pkg::ST_EMIT : lcb_pkg::ST_SUM;
				end
				lcb_pkg::ST_SUM: begin
					pend_q <= issue && include_i;
					if (issue) begin
						slot_q <= slot_q + 1'b1;
					end else begin
						start_q <= 1'b1;
						state_q <= lcb_pkg::ST_DLO;
					end
				end
				lcb_pkg::ST_DLO: begin
					if (dres.done) begin
						start_q <= 1'b1;
						state_q <= lcb_pkg::ST_DHI;
					end
				end
				lcb_pkg::ST_DHI: begin
					if (dres.done) begin
						state_q <= lcb_pkg::ST_EMIT;
					end
				end
				lcb_pkg::ST_EMIT: begin
					if (m_tready) begin
						if (col_q == p_q - 1'b1) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
							state_q <= (row_q == q_q - 1'b1) ? lcb_pkg::ST_IDLE
								: lcb_pkg::ST_SETUP;
						end else begin
							col_q <= col_q + 1'b1;
							state_q <= lcb_pkg::ST_SETUP;
						end
					end
				end
				default: state_q <= lcb_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= bound * xi;
		which_q <= slot_q[0];
		case (state_q)
			lcb_pkg::ST_SETUP: begin
				smax_q <= '0;
				smin_q <= '0;
				out_last_q <= (row_q == q_q - 1'b1) && (col_q == p_q - 1'b1);
				out_bad_q <= lb_q > ub_q;
				out_min_q <= (lb_q > ub_q) ? '0 : lb_q;
				out_max_q <= (lb_q > ub_q) ? '0 : ub_q;
			end
			lcb_pkg::ST_SUM: begin
				if (pend_q) begin
					if (which_q) begin
						smin_q <= smin_q + term;
					end else begin
						smax_q <= smax_q + term;
					end
				end
			end
			lcb_pkg::ST_DLO: begin
				if (dres.done) begin
					lo_q <= dres.quot;
					lo_bad_q <= dres.ovf;
				end
			end
			lcb_pkg::ST_DHI: begin
				if (dres.done) begin
					out_bad_q <= lo_bad_q || dres.ovf || (mn > mx);
					out_min_q <= (lo_bad_q || dres.ovf || (mn > mx)) ? '0 : mn;
					out_max_q <= (lo_bad_q || dres.ovf || (mn > mx)) ? '0 : mx;
				end
			end
			default: ;
		endcase
	end

	assign s_tready = state_q == lcb_pkg::ST_IDLE;
	assign m_tvalid = state_q == lcb_pkg::ST_EMIT;
	assign m_tdata = {2'b00, out_max_q, out_min_q, col_q[2:0], row_q[2:0]};
	assign m_tuser = out_bad_q;
	assign m_tlast = out_last_q;

	`LCB_ASSERT_NEXT(a_last_frees_input, m_tvalid && m_tready && m_tlast, s_tready,
		"Input not ready after the last transfer of a run.")
	`LCB_ASSERT_NOW(a_infeasible_zero, m_tvalid && m_tuser, m_tdata[69:6] == '0,
		"Infeasible result carries nonzero bounds.")
	`LCB_ASSERT_NOW(a_no_overlap, s_tready, !m_tvalid,
		"Input accepted while a result is pending.")

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	class bounds_scoreboard;
		logic signed [31:0] box_lo;
		logic signed [31:0] box_hi;
		logic [3:0] x_columns;
		logic [3:0] y_columns;
		logic signed [31:0] x_row[8];
		logic signed [31:0] y_row[8];
		logic [71:0] pending_data[$];
		logic pending_infeasible[$];
		logic pending_last[$];
		int errors;

		function new();
			box_lo = 0;
			box_hi = 65536;
			x_columns = 8;
			y_columns = 8;
			errors = 0;
			for (int i = 0; i < 8; i++) begin
				x_row[i] = 0;
				y_row[i] = 0;
			end
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				lcb_pkg::REG_LOWER: box_lo = val;
				lcb_pkg::REG_UPPER: box_hi = val;
				lcb_pkg::REG_X_COLS: x_columns = val[3:0];
				lcb_pkg::REG_Y_COLS: y_columns = val[3:0];
				default: ;
			endcase
		endfunction

		function longint scaled_product(longint a, longint b);
			longint prod;
			prod = a * b;
			return prod >>> lcb_pkg::DEF_FRAC_BITS;
		endfunction

		function bit fixed_divide(longint num, longint den, output logic signed [31:0] q);
			logic signed [127:0] wide;
			logic signed [127:0] quo;
			wide = num;
			wide = wide <<< lcb_pkg::DEF_FRAC_BITS;
			quo = wide / den;
			q = quo[31:0];
			return (quo >= -128'sd2147483648 && quo <= 128'sd2147483647);
		endfunction

		function void note_input(logic [1:0] mode, logic [2:0] idx, logic signed [31:0] val);
			int p;
			int q;
			logic signed [31:0] mn, mx, lo_q, hi_q;
			longint smax, smin;
			bit bad;
			if (mode == lcb_pkg::MODE_LOAD_X) begin
				x_row[idx] = val;
				return;
			end
			if (mode == lcb_pkg::MODE_LOAD_Y) begin
				y_row[idx] = val;
				return;
			end
			if (mode != lcb_pkg::MODE_COMPUTE)
				return;
			p = (x_columns > 8) ? 8 : x_columns;
			q = (y_columns > 8) ? 8 : y_columns;
			for (int r = 0; r < q; r++) begin
				for (int c = 0; c < p; c++) begin
					mn = box_lo;
					mx = box_hi;
					bad = 0;
					if (x_row[c] != 0) begin
						smax = 0;
						smin = 0;
						lo_q = 0;
						hi_q = 0;
						for (int i = 0; i < p; i++) begin
							if (i != c && x_row[i] > 0) begin
								smax += scaled_product(box_hi, x_row[i]);
								smin += scaled_product(box_lo, x_row[i]);
							end
						end
						if (!fixed_divide(longint'(y_row[r]) - smax, x_row[c], lo_q))
							bad = 1;
						if (!fixed_divide(longint'(y_row[r]) - smin, x_row[c], hi_q))
							bad = 1;
						if (bad) begin
							lo_q = 0;
							hi_q = 0;
						end
						if (lo_q > mn) mn = lo_q;
						if (hi_q < mx) mx = hi_q;
					end
					if (mn > mx)
						bad = 1;
					if (bad) begin
						mn = 0;
						mx = 0;
					end
					pending_data.push_back({2'b0, mx, mn, c[2:0], r[2:0]});
					pending_infeasible.push_back(bad);
					pending_last.push_back(r == q - 1 && c == p - 1);
				end
			end
		endfunction

		task report_mismatch(string what, logic [71:0] got, logic [71:0] want);
			$display("mismatch %s: got %h expected %h", what, got, want);
			errors++;
		endtask

		task check_result(logic [71:0] data, logic infeasible, logic last);
			logic [71:0] want;
			logic want_inf, want_last;
			if (pending_data.size() == 0) begin
				report_mismatch("unexpected transfer", data, '0);
				return;
			end
			want = pending_data.pop_front();
			want_inf = pending_infeasible.pop_front();
			want_last = pending_last.pop_front();
			if (data[2:0] !== want[2:0])
				report_mismatch("entry_row", 72'(data[2:0]), 72'(want[2:0]));
			if (data[5:3] !== want[5:3])
				report_mismatch("entry_col", 72'(data[5:3]), 72'(want[5:3]));
			if (data[37:6] !== want[37:6])
				report_mismatch("min_bound", 72'(data[37:6]), 72'(want[37:6]));
			if (data[69:38] !== want[69:38])
				report_mismatch("max_bound", 72'(data[69:38]), 72'(want[69:38]));
			if (infeasible !== want_inf)
				report_mismatch("infeasible", 72'(infeasible), 72'(want_inf));
			if (last !== want_last)
				report_mismatch("last", 72'(last), 72'(want_last));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [39:0] s_tdata = 0;
	logic [1:0] s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [71:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_we = 0;
	logic [1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	bounds_scoreboard bounds_sb = new();
	int idle_cycles = 0;
	localparam int WATCHDOG_LIMIT = 200000;

	linear_constraint_entry_bounds_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			bounds_sb.check_result(m_tdata, m_tuser, m_tlast);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[linear_constraint_entry_bounds_unit] ERROR");
			$finish;
		end
	end

	initial begin
		int gap;
		wait (arst_n);
		forever begin
			gap = $urandom_range(0, 17);
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		bounds_sb.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_item(logic [1:0] mode, logic [2:0] idx, logic [31:0] val, int gap);
		if (gap > 0) begin
			@(posedge clk);
			s_tvalid <= 0;
			repeat (gap - 1) @(posedge clk);
		end
		@(posedge clk);
		s_tvalid <= 1;
		s_tuser <= mode;
		s_tdata <= {5'b0, val, idx};
		do @(posedge clk); while (!s_tready);
		bounds_sb.note_input(mode, idx, val);
		s_tvalid <= 0;
	endtask

	task automatic drain();
		while (bounds_sb.pending_data.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic logic [31:0] random_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 0;
			3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic load_row(int p, int q, bit tiny);
		for (int i = 0; i < p; i++)
			send_item(lcb_pkg::MODE_LOAD_X, 3'(i),
				tiny ? ($urandom_range(0, 32'h40000) - 32'h20000)
				: random_value(), $urandom_range(0, 17));
		for (int i = 0; i < q; i++)
			send_item(lcb_pkg::MODE_LOAD_Y, 3'(i),
				tiny ? ($urandom_range(0, 32'h40000) - 32'h20000)
				: random_value(), $urandom_range(0, 17));
	endtask

	initial begin
		int p, q, n, reps;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		for (int i = 0; i < 8; i++) begin
			send_item(lcb_pkg::MODE_LOAD_X, 3'(i), (i == 0) ? 32'h8000_0000
				: (i == 1) ? 32'h7fff_ffff : (i == 2) ? 0 : 32'h0001_0000 * i, 0);
			send_item(lcb_pkg::MODE_LOAD_Y, 3'(i), (i == 0) ? 32'h7fff_ffff
				: (i == 1) ? 32'h8000_0000 : 32'h0003_0000 - i, 0);
		end
		send_item(lcb_pkg::MODE_COMPUTE, 0, 0, 0);
		send_item(MODE_UNUSED, 7, 32'hffff_ffff, 0);
		drain();
		write_reg(lcb_pkg::REG_LOWER, 32'h8000_0000);
		write_reg(lcb_pkg::REG_UPPER, 32'h7fff_ffff);
		write_reg(lcb_pkg::REG_X_COLS, 1);
		write_reg(lcb_pkg::REG_Y_COLS, 1);
		send_item(lcb_pkg::MODE_COMPUTE, 7, 32'hffff_ffff, 0);
		drain();
		write_reg(lcb_pkg::REG_X_COLS, 0);
		send_item(lcb_pkg::MODE_COMPUTE, 0, 0, 0);
		drain();
		write_reg(lcb_pkg::REG_X_COLS, 15);
		write_reg(lcb_pkg::REG_Y_COLS, 2);
		write_reg(lcb_pkg::REG_LOWER, 32'h0002_0000);
		write_reg(lcb_pkg::REG_UPPER, 32'hfffe_0000);
		send_item(lcb_pkg::MODE_COMPUTE, 0, 0, 0);
		drain();
		n = 0;
		while (n < 450) begin
			p = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
			q = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
			write_reg(lcb_pkg::REG_X_COLS, p);
			write_reg(lcb_pkg::REG_Y_COLS, q);
			write_reg(lcb_pkg::REG_LOWER, ($urandom_range(0, 1)) ? random_value()
				: -$urandom_range(0, 32'h30000));
			write_reg(lcb_pkg::REG_UPPER, ($urandom_range(0, 1)) ? random_value()
				: $urandom_range(0, 32'h30000));
			load_row(p, q, $urandom_range(0, 1));
			n += p + q;
			reps = $urandom_range(1, 3);
			for (int k = 0; k < reps; k++) begin
				if ($urandom_range(0, 4) == 0) begin
					send_item(MODE_UNUSED, 3'($urandom), $urandom, $urandom_range(0, 17));
				end else if ($urandom_range(0, 3) == 0) begin
					send_item(lcb_pkg::MODE_LOAD_X, 3'($urandom_range(0, p - 1)),
						random_value(), $urandom_range(0, 17));
					n++;
				end
				send_item(lcb_pkg::MODE_COMPUTE, 3'($urandom), $urandom,
					$urandom_range(0, 17));
				n++;
			end
			drain();
		end
		if (bounds_sb.errors == 0 && bounds_sb.pending_data.size() == 0)
			$display("[linear_constraint_entry_bounds_unit] OK");
		else
			$display("[linear_constraint_entry_bounds_unit] ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+sv
sv/lcb_pkg.sv
sv/lcb_div.sv
sv/linear_constraint_entry_bounds_unit.sv
tb/tb_top.sv
